// File: rtl/ewseq_pkg.sv
// Package for the electrochemical waveform sequencer: request and result types,
// register layout, run phase codes and field widths.
// No dependencies; used by ewseq_step and the top level.
package ewseq_pkg;

  localparam int DAC_BITS        = 10;
  localparam int TICK_COUNT_BITS = 16;
  localparam int ADC_BITS        = 10;
  localparam int IDX_BITS        = 24;
  localparam int CYC_BITS        = 8;
  localparam int DEC_BITS        = 8;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_CODE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_CODE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_TICKS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CYCLE_COUNT  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECIMATION   = 3'd6;

  // Mode codes
  localparam logic MODE_CHRONO = 1'b0;
  localparam logic MODE_CV     = 1'b1;

  // Request function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                    func;
    logic [ADC_BITS-1:0]     adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [DAC_BITS-1:0]     dac_code;
    logic                    report;
    logic [IDX_BITS-1:0]     sample_index;
    logic [ADC_BITS-1:0]     current_raw;
    logic [1:0]              run_phase;
    logic                    run_done;
  } out_item_t;

  typedef struct packed {
    logic                       mode;
    logic [DAC_BITS-1:0]        first_code;
    logic [DAC_BITS-1:0]        second_code;
    logic [TICK_COUNT_BITS-1:0] hold_ticks;
    logic [TICK_COUNT_BITS-1:0] second_ticks;
    logic [CYC_BITS-1:0]        cycle_count;
    logic [DEC_BITS-1:0]        decimation;
  } cfg_t;

  typedef struct packed {
    phase_t                     phase;
    logic [DAC_BITS-1:0]        level;
    logic [CYC_BITS-1:0]        cycles_done;
    logic [TICK_COUNT_BITS-1:0] phase_ticks;
    logic [DEC_BITS-1:0]        decim_count;
    logic [IDX_BITS-1:0]        tick_index;
  } state_t;

endpackage

// File: rtl/ewseq_step.sv
// Next-state and result logic for one request of the waveform sequencer.
// Purely combinational; depends on ewseq_pkg.
module ewseq_step (
  input  ewseq_pkg::cfg_t      cfg,
  input  ewseq_pkg::state_t    cur,
  input  ewseq_pkg::in_item_t  item,
  output ewseq_pkg::state_t    nxt,
  output ewseq_pkg::out_item_t res
);

  always_comb begin
    logic [ewseq_pkg::DEC_BITS-1:0]        dec_eff;
    logic [ewseq_pkg::DEC_BITS-1:0]        dec_inc;
    logic [ewseq_pkg::TICK_COUNT_BITS-1:0] ticks_inc;
    logic [ewseq_pkg::CYC_BITS-1:0]        cyc_inc;
    logic                                  rep;
    logic                                  done;

    nxt       = cur;
    rep       = 1'b0;
    done      = 1'b0;
    dec_eff   = (cfg.decimation == '0) ? ewseq_pkg::DEC_BITS'(1) : cfg.decimation;
    dec_inc   = cur.decim_count + ewseq_pkg::DEC_BITS'(1);
    ticks_inc = cur.phase_ticks + ewseq_pkg::TICK_COUNT_BITS'(1);
    cyc_inc   = cur.cycles_done + ewseq_pkg::CYC_BITS'(1);

    // Default result: held state, nothing reported
    res.dac_code     = cur.level;
    res.report       = 1'b0;
    res.sample_index = cur.tick_index;
    res.current_raw  = '0;
    res.run_phase    = cur.phase;
    res.run_done     = 1'b0;

    if (item.func == ewseq_pkg::FUNC_START) begin
      // Start is taken only when idle; result shows the state after it
      if (cur.phase == ewseq_pkg::PH_IDLE) begin
        nxt.tick_index  = '0;
        nxt.phase_ticks = '0;
        nxt.cycles_done = '0;
        if (cfg.mode == ewseq_pkg::MODE_CHRONO) begin
          if (cfg.hold_ticks != '0) begin
            nxt.phase = ewseq_pkg::PH_ONE;
            nxt.level = cfg.first_code;
          end else if (cfg.second_ticks != '0) begin
            nxt.phase = ewseq_pkg::PH_TWO;
            nxt.level = cfg.second_code;
          end else begin
            nxt.phase = ewseq_pkg::PH_IDLE;
          end
        end else begin
          if (cfg.cycle_count != '0 && cfg.first_code <= cfg.second_code) begin
            nxt.phase = ewseq_pkg::PH_ONE;
            nxt.level = cfg.first_code;
          end else begin
            nxt.phase = ewseq_pkg::PH_IDLE;
          end
        end
      end
      res.dac_code     = nxt.level;
      res.sample_index = nxt.tick_index;
      res.run_phase    = nxt.phase;
    end else if (cur.phase != ewseq_pkg::PH_IDLE) begin
      // Active tick: drive the current level, then advance the run
      nxt.tick_index = cur.tick_index + ewseq_pkg::IDX_BITS'(1);
      if (cfg.mode == ewseq_pkg::MODE_CHRONO) begin
        rep             = 1'b1;
        nxt.phase_ticks = ticks_inc;
        if (cur.phase == ewseq_pkg::PH_ONE) begin
          if (ticks_inc >= cfg.hold_ticks) begin
            nxt.phase_ticks = '0;
            if (cfg.second_ticks != '0) begin
              nxt.phase = ewseq_pkg::PH_TWO;
              nxt.level = cfg.second_code;
            end else begin
              done = 1'b1;
            end
          end
        end else if (ticks_inc >= cfg.second_ticks) begin
          done = 1'b1;
        end
      end else begin
        // Decimation counter persists across runs
        nxt.decim_count = dec_inc;
        if (dec_inc >= dec_eff) begin
          nxt.decim_count = '0;
          rep             = 1'b1;
        end
        // Triangle sweep; turning codes are driven on two ticks
        if (cur.phase == ewseq_pkg::PH_ONE) begin
          if (cur.level >= cfg.second_code) begin
            nxt.phase = ewseq_pkg::PH_TWO;
          end else begin
            nxt.level = cur.level + ewseq_pkg::DAC_BITS'(1);
          end
        end else begin
          if (cur.level <= cfg.first_code) begin
            nxt.cycles_done = cyc_inc;
            if (cyc_inc >= cfg.cycle_count) begin
              done = 1'b1;
            end else begin
              nxt.phase = ewseq_pkg::PH_ONE;
            end
          end else begin
            nxt.level = cur.level - ewseq_pkg::DAC_BITS'(1);
          end
        end
      end
      if (done) begin
        nxt.phase = ewseq_pkg::PH_IDLE;
      end
      res.report       = rep;
      res.sample_index = nxt.tick_index;
      res.current_raw  = rep ? item.adc_sample : '0;
      res.run_done     = done;
    end
  end

endmodule

// File: rtl/electrochemical_waveform_sequencer.sv
// Top level of the electrochemical waveform sequencer: configuration registers,
// run state, request intake and the result register. Uses ewseq_pkg, ewseq_step.
//
//   channel  direction  handshake           payload
//   in       request    in_valid/in_stall   in_data   (ewseq_pkg::in_item_t)
//   out      result     out_valid/out_stall out_data  (ewseq_pkg::out_item_t)
//   cfg      write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each request updates the run state and loads the result register at the same
// edge, so one request per cycle is sustained while in_stall is low. rst
// (synchronous) returns registers to defaults and the run to idle. in_stall rises
// only while a result is held under out_stall.
module electrochemical_waveform_sequencer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  ewseq_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output ewseq_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ewseq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ewseq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  ewseq_pkg::cfg_t      cfg;
  ewseq_pkg::state_t    state;
  ewseq_pkg::state_t    state_next;
  ewseq_pkg::out_item_t res;
  logic                 accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  ewseq_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (in_data),
    .nxt  (state_next),
    .res  (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= ewseq_pkg::MODE_CV;
      cfg.first_code   <= ewseq_pkg::DAC_BITS'(0);
      cfg.second_code  <= ewseq_pkg::DAC_BITS'(1023);
      cfg.hold_ticks   <= ewseq_pkg::TICK_COUNT_BITS'(34);
      cfg.second_ticks <= ewseq_pkg::TICK_COUNT_BITS'(172);
      cfg.cycle_count  <= ewseq_pkg::CYC_BITS'(1);
      cfg.decimation   <= ewseq_pkg::DEC_BITS'(4);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ewseq_pkg::REG_MODE:         cfg.mode <= cfg_data[0];
        ewseq_pkg::REG_FIRST_CODE:   cfg.first_code <= cfg_data[ewseq_pkg::DAC_BITS-1:0];
        ewseq_pkg::REG_SECOND_CODE:  cfg.second_code <= cfg_data[ewseq_pkg::DAC_BITS-1:0];
        ewseq_pkg::REG_HOLD_TICKS:
          cfg.hold_ticks <= cfg_data[ewseq_pkg::TICK_COUNT_BITS-1:0];
        ewseq_pkg::REG_SECOND_TICKS:
          cfg.second_ticks <= cfg_data[ewseq_pkg::TICK_COUNT_BITS-1:0];
        ewseq_pkg::REG_CYCLE_COUNT:  cfg.cycle_count <= cfg_data[ewseq_pkg::CYC_BITS-1:0];
        ewseq_pkg::REG_DECIMATION:   cfg.decimation <= cfg_data[ewseq_pkg::DEC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= ewseq_pkg::PH_IDLE;
      state.level       <= '0;
      state.cycles_done <= '0;
      state.phase_ticks <= '0;
      state.decim_count <= '0;
      state.tick_index  <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule
